// ===== hdl/kvbac_pkg.sv =====
// ----------------------------------------------------------------------------
// kvbac_pkg
// Shared types, constants and the hash step of the kv block allocator.
// ----------------------------------------------------------------------------
package kvbac_pkg;

	// pool geometry
	localparam int POOL_BLOCKS = 256;
	localparam int BLK_W       = $clog2(POOL_BLOCKS);
	localparam int MAX_TOK     = 16;
	localparam int TIDX_W      = $clog2(MAX_TOK);
	localparam int PCNT_W      = $clog2(MAX_TOK + 1);
	localparam int TOKEN_BITS  = 32;
	localparam int HASH_W      = 64;
	localparam int REF_W       = 16;
	localparam int FREE_W      = $clog2(POOL_BLOCKS + 1);
	localparam int REUSE_W     = 16;
	localparam int CFG_W       = 5;
	localparam int STOK_AW     = BLK_W + TIDX_W;

	// hash prime split as 2^40 + 0x1b3
	localparam int         HASH_HI_SH = 40;
	localparam logic [8:0] HASH_LO    = 9'h1B3;

	// opcodes
	localparam logic [1:0] OP_TOKEN   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_APPEND  = 2'd2;
	localparam logic [1:0] OP_STATUS  = 2'd3;

	// result status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_NO_FREE = 2'd1;
	localparam logic [1:0] STS_BAD_REL = 2'd2;
	localparam logic [1:0] STS_SAT     = 2'd3;

	// controller states
	typedef enum logic [3:0] {
		S_IDLE, S_HASH, S_SCAN_INIT, S_SCAN, S_SCAN_DEC, S_CMP_INIT, S_CMP,
		S_CMP_DEC, S_REF_RD, S_HIT_WR, S_REL_WR, S_POP_RD, S_FILL, S_APP_WR,
		S_OOM, S_EMIT
	} ctrl_state_t;

	// datapath commands
	typedef enum logic [3:0] {
		CMD_NONE, CMD_LATCH, CMD_HASH, CMD_SCAN_INIT, CMD_SCAN, CMD_CMP_INIT,
		CMD_CMP, CMD_REF_RD, CMD_HIT_WR, CMD_REL_WR, CMD_POP_RD, CMD_FILL,
		CMD_APP_WR, CMD_OOM, CMD_EMIT
	} dp_cmd_t;

	// datapath status towards the controller
	typedef struct packed {
		logic [1:0] op;
		logic       block_end;
		logic       scan_done;
		logic       cand_ok;
		logic       cmp_done;
		logic       mism;
		logic       fill_done;
		logic       empty;
		logic       emit_ok;
	} dp_stat_t;

	// one chained hash step: (h ^ tok) * prime, modulo 2^64
	function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
			input logic [TOKEN_BITS-1:0] tok);
		logic [HASH_W-1:0] x;
		x = h ^ HASH_W'(tok);
		return (x << HASH_HI_SH) + (x * HASH_W'(HASH_LO));
	endfunction

endpackage

// ===== hdl/kvbac_ctrl.sv =====
// ----------------------------------------------------------------------------
// kvbac_ctrl
// Sequencer of the block allocator: walks each transaction through the
// datapath steps by issuing one command per cycle.
// ----------------------------------------------------------------------------
module kvbac_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  logic [1:0]          opcode,
	input  kvbac_pkg::dp_stat_t stat,
	output kvbac_pkg::dp_cmd_t  cmd,
	output logic                idle
);
	import kvbac_pkg::*;

	ctrl_state_t state_q, state_nxt;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_nxt;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					case (opcode)
						OP_TOKEN:   state_nxt = S_HASH;
						OP_RELEASE: state_nxt = S_REF_RD;
						OP_APPEND:  state_nxt = stat.empty ? S_OOM : S_POP_RD;
						default:    state_nxt = S_EMIT;
					endcase
				end
			end
			S_HASH:      state_nxt = stat.block_end ? S_SCAN_INIT : S_IDLE;
			S_SCAN_INIT: state_nxt = S_SCAN;
			S_SCAN:      if (stat.scan_done) state_nxt = S_SCAN_DEC;
			S_SCAN_DEC: begin
				if (stat.cand_ok) state_nxt = S_CMP_INIT;
				else state_nxt = stat.empty ? S_OOM : S_POP_RD;
			end
			S_CMP_INIT:  state_nxt = S_CMP;
			S_CMP:       if (stat.cmp_done) state_nxt = S_CMP_DEC;
			S_CMP_DEC: begin
				if (!stat.mism) state_nxt = S_REF_RD;
				else state_nxt = stat.empty ? S_OOM : S_POP_RD;
			end
			S_REF_RD:    state_nxt = (stat.op == OP_RELEASE) ? S_REL_WR : S_HIT_WR;
			S_HIT_WR:    state_nxt = S_EMIT;
			S_REL_WR:    state_nxt = S_EMIT;
			S_POP_RD:    state_nxt = (stat.op == OP_APPEND) ? S_APP_WR : S_FILL;
			S_FILL:      if (stat.fill_done) state_nxt = S_EMIT;
			S_APP_WR:    state_nxt = S_EMIT;
			S_OOM:       state_nxt = S_EMIT;
			S_EMIT:      if (stat.emit_ok) state_nxt = S_IDLE;
			default:     state_nxt = S_IDLE;
		endcase
	end

	// command decode
	always_comb begin
		cmd  = CMD_NONE;
		idle = 1'b0;
		case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				cmd  = item_valid ? CMD_LATCH : CMD_NONE;
			end
			S_HASH:      cmd = CMD_HASH;
			S_SCAN_INIT: cmd = CMD_SCAN_INIT;
			S_SCAN:      cmd = CMD_SCAN;
			S_CMP_INIT:  cmd = CMD_CMP_INIT;
			S_CMP:       cmd = CMD_CMP;
			S_REF_RD:    cmd = CMD_REF_RD;
			S_HIT_WR:    cmd = CMD_HIT_WR;
			S_REL_WR:    cmd = CMD_REL_WR;
			S_POP_RD:    cmd = CMD_POP_RD;
			S_FILL:      cmd = CMD_FILL;
			S_APP_WR:    cmd = CMD_APP_WR;
			S_OOM:       cmd = CMD_OOM;
			S_EMIT:      cmd = CMD_EMIT;
			default:     cmd = CMD_NONE;
		endcase
	end

endmodule

// ===== hdl/kvbac_dp.sv =====
// ----------------------------------------------------------------------------
// kvbac_dp
// Datapath of the block allocator: pending block, hash chain, block tables,
// free list and the result register.
// ----------------------------------------------------------------------------
module kvbac_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  kvbac_pkg::dp_cmd_t                  cmd,
	output kvbac_pkg::dp_stat_t                 stat,
	input  logic                                cfg_we,
	input  logic [kvbac_pkg::CFG_W-1:0]         cfg_data,
	output logic [kvbac_pkg::CFG_W-1:0]         tpb,
	input  logic [1:0]                          opcode,
	input  logic [kvbac_pkg::TOKEN_BITS-1:0]    token,
	input  logic                                last_token,
	input  logic [kvbac_pkg::BLK_W-1:0]         release_block,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [kvbac_pkg::BLK_W-1:0]         block_num,
	output logic                                cache_hit,
	output logic [1:0]                          status,
	output logic [kvbac_pkg::FREE_W-1:0]        free_count,
	output logic [kvbac_pkg::REUSE_W-1:0]       hit_tokens,
	output logic                                sequence_done
);
	import kvbac_pkg::*;

	// latched transaction
	logic [1:0]            op_q;
	logic [TOKEN_BITS-1:0] tok_q;
	logic                  last_q;
	logic [BLK_W-1:0]      rel_q;

	// sequence state
	logic [CFG_W-1:0]      tpb_q;
	logic [TOKEN_BITS-1:0] pend_q [MAX_TOK];
	logic [PCNT_W-1:0]     pcnt_q;
	logic [HASH_W-1:0]     run_hash_q;
	logic [REUSE_W-1:0]    reused_q;

	// per-block flags
	logic [POOL_BLOCKS-1:0] reg_q;
	logic [POOL_BLOCKS-1:0] inuse_q;

	// free list
	logic [BLK_W-1:0]      head_q, tail_q;
	logic [FREE_W-1:0]     total_q, wcnt_q;

	// block tables
	logic [HASH_W-1:0]     shash_mem [POOL_BLOCKS];
	logic [PCNT_W-1:0]     slen_mem  [POOL_BLOCKS];
	logic [REF_W-1:0]      rcnt_mem  [POOL_BLOCKS];
	logic [BLK_W-1:0]      fifo_mem  [POOL_BLOCKS];
	logic [TOKEN_BITS-1:0] stok_mem  [POOL_BLOCKS*MAX_TOK];

	// scan pipeline
	logic [BLK_W:0]        sa_q;
	logic                  sv_s1;
	logic [BLK_W-1:0]      si_s1;
	logic [HASH_W-1:0]     hrd_s1;
	logic [PCNT_W-1:0]     lrd_s1;
	logic                  found_q, lenok_q;
	logic [BLK_W-1:0]      cand_q;

	// compare pipeline
	logic [PCNT_W-1:0]     ca_q;
	logic                  cv_s1;
	logic [TIDX_W-1:0]     ci_s1;
	logic [TOKEN_BITS-1:0] trd_s1;
	logic                  mism_q;

	// reference count read, popped block, fill counter
	logic [REF_W-1:0]      rc_rd_s1;
	logic                  iu_rd_s1;
	logic [BLK_W-1:0]      ffrd_q, hdrd_q;
	logic                  ffw_q;
	logic [PCNT_W-1:0]     fa_q;

	// result being built and the output register
	logic [BLK_W-1:0]      res_blk_q;
	logic                  res_hit_q;
	logic [1:0]            res_st_q;
	logic                  out_vld_q;
	logic [BLK_W-1:0]      out_blk_q;
	logic                  out_hit_q;
	logic [1:0]            out_st_q;
	logic [FREE_W-1:0]     out_free_q;
	logic [REUSE_W-1:0]    out_reuse_q;
	logic                  out_done_q;

	// combinational helpers
	logic [PCNT_W-1:0]     bsize, pcnt_nxt;
	logic [BLK_W-1:0]      pb, ref_addr;
	logic [REF_W-1:0]      rc_eff, rc_wd;
	logic                  rc_we;
	logic [BLK_W-1:0]      rc_wa;
	logic                  commit, push, emit_ok, scan_hit;
	logic [REUSE_W:0]      reuse_sum;

	// effective block size and the count after this token
	always_comb begin
		if (tpb_q == '0) bsize = PCNT_W'(1);
		else if (tpb_q > CFG_W'(MAX_TOK)) bsize = PCNT_W'(MAX_TOK);
		else bsize = PCNT_W'(tpb_q);
		pcnt_nxt = (pcnt_q < PCNT_W'(MAX_TOK)) ? pcnt_q + PCNT_W'(1) : pcnt_q;
	end

	// popped block, counter addressing and reference count writes
	always_comb begin
		pb        = ffw_q ? ffrd_q : hdrd_q;
		ref_addr  = (op_q == OP_RELEASE) ? rel_q : cand_q;
		rc_eff    = iu_rd_s1 ? rc_rd_s1 : '0;
		commit    = (cmd == CMD_FILL) && (fa_q == pcnt_q - PCNT_W'(1));
		push      = (cmd == CMD_REL_WR) && (rc_eff == REF_W'(1));
		emit_ok   = !out_vld_q || !result_stall;
		scan_hit  = sv_s1 && reg_q[si_s1] && (hrd_s1 == run_hash_q);
		reuse_sum = {1'b0, reused_q} + (REUSE_W+1)'(pcnt_q);
		rc_we     = 1'b0;
		rc_wa     = pb;
		rc_wd     = REF_W'(1);
		case (cmd)
			CMD_HIT_WR: begin
				rc_we = (rc_eff != '1);
				rc_wa = cand_q;
				rc_wd = rc_eff + REF_W'(1);
			end
			CMD_REL_WR: begin
				rc_we = (rc_eff != '0);
				rc_wa = rel_q;
				rc_wd = rc_eff - REF_W'(1);
			end
			CMD_FILL:   rc_we = commit;
			CMD_APP_WR: rc_we = 1'b1;
			default:    rc_we = 1'b0;
		endcase
	end

	// status to the controller
	always_comb begin
		stat.op        = op_q;
		stat.block_end = (pcnt_nxt >= bsize) || last_q;
		stat.scan_done = sv_s1 && (si_s1 == BLK_W'(POOL_BLOCKS - 1));
		stat.cand_ok   = found_q && lenok_q;
		stat.cmp_done  = cv_s1 && (ci_s1 == TIDX_W'(pcnt_q - PCNT_W'(1)));
		stat.mism      = mism_q;
		stat.fill_done = commit;
		stat.empty     = (total_q == '0);
		stat.emit_ok   = emit_ok;
	end

	// control and sequence registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpb_q      <= CFG_W'(MAX_TOK);
			pcnt_q     <= '0;
			run_hash_q <= '0;
			reused_q   <= '0;
			reg_q      <= '0;
			inuse_q    <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			total_q    <= FREE_W'(POOL_BLOCKS);
			wcnt_q     <= '0;
			sa_q       <= '0;
			sv_s1      <= 1'b0;
			found_q    <= 1'b0;
			ca_q       <= '0;
			cv_s1      <= 1'b0;
			mism_q     <= 1'b0;
			fa_q       <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_we) tpb_q <= cfg_data;
			case (cmd)
				CMD_HASH: begin
					pcnt_q     <= pcnt_nxt;
					run_hash_q <= hash_step(run_hash_q, tok_q);
				end
				CMD_SCAN_INIT: begin
					sa_q    <= '0;
					sv_s1   <= 1'b0;
					found_q <= 1'b0;
				end
				CMD_SCAN: begin
					sv_s1 <= !sa_q[BLK_W];
					if (!sa_q[BLK_W]) sa_q <= sa_q + (BLK_W+1)'(1);
					if (scan_hit) found_q <= 1'b1;
				end
				CMD_CMP_INIT: begin
					ca_q   <= '0;
					cv_s1  <= 1'b0;
					mism_q <= 1'b0;
				end
				CMD_CMP: begin
					cv_s1 <= (ca_q < pcnt_q);
					if (ca_q < pcnt_q) ca_q <= ca_q + PCNT_W'(1);
					if (cv_s1 && (trd_s1 != pend_q[ci_s1])) mism_q <= 1'b1;
				end
				CMD_HIT_WR: begin
					reused_q <= reuse_sum[REUSE_W] ? '1 : reuse_sum[REUSE_W-1:0];
				end
				CMD_REL_WR: begin
					if (push) begin
						reg_q[rel_q]   <= 1'b0;
						inuse_q[rel_q] <= 1'b0;
						tail_q         <= tail_q + BLK_W'(1);
						total_q        <= total_q + FREE_W'(1);
						if (wcnt_q != FREE_W'(POOL_BLOCKS)) wcnt_q <= wcnt_q + FREE_W'(1);
					end
				end
				CMD_POP_RD: begin
					head_q  <= head_q + BLK_W'(1);
					total_q <= total_q - FREE_W'(1);
					fa_q    <= '0;
				end
				CMD_FILL: begin
					fa_q <= fa_q + PCNT_W'(1);
					if (commit) begin
						// drop any older block that carries the same hash
						if (found_q) reg_q[cand_q] <= 1'b0;
						reg_q[pb]   <= 1'b1;
						inuse_q[pb] <= 1'b1;
					end
				end
				CMD_APP_WR: begin
					reg_q[pb]   <= 1'b0;
					inuse_q[pb] <= 1'b1;
				end
				CMD_EMIT: begin
					if (emit_ok && op_q == OP_TOKEN) begin
						pcnt_q <= '0;
						if (last_q) begin
							run_hash_q <= '0;
							reused_q   <= '0;
						end
					end
				end
				default: ;
			endcase
			// output register handshake
			if (cmd == CMD_EMIT && emit_ok) out_vld_q <= 1'b1;
			else if (!result_stall) out_vld_q <= 1'b0;
		end
	end

	// transaction payload and result fields
	always_ff @(posedge clk) begin
		case (cmd)
			CMD_LATCH: begin
				op_q      <= opcode;
				tok_q     <= token;
				last_q    <= last_token;
				rel_q     <= release_block;
				res_blk_q <= '0;
				res_hit_q <= 1'b0;
				res_st_q  <= STS_OK;
			end
			CMD_HASH: begin
				if (pcnt_q < PCNT_W'(MAX_TOK)) pend_q[pcnt_q[TIDX_W-1:0]] <= tok_q;
			end
			CMD_SCAN: begin
				if (scan_hit) begin
					cand_q  <= si_s1;
					lenok_q <= (lrd_s1 == pcnt_q);
				end
			end
			CMD_HIT_WR: begin
				res_blk_q <= cand_q;
				res_hit_q <= 1'b1;
				res_st_q  <= (rc_eff == '1) ? STS_SAT : STS_OK;
			end
			CMD_REL_WR: begin
				res_blk_q <= rel_q;
				res_st_q  <= (rc_eff == '0) ? STS_BAD_REL : STS_OK;
			end
			CMD_FILL:   res_blk_q <= pb;
			CMD_APP_WR: res_blk_q <= pb;
			CMD_OOM: begin
				res_blk_q <= '0;
				res_st_q  <= STS_NO_FREE;
			end
			CMD_EMIT: begin
				if (emit_ok) begin
					out_blk_q   <= res_blk_q;
					out_hit_q   <= res_hit_q;
					out_st_q    <= res_st_q;
					out_free_q  <= total_q;
					out_reuse_q <= reused_q;
					out_done_q  <= (op_q == OP_TOKEN) && last_q;
				end
			end
			default: ;
		endcase
	end

	// hash and length tables
	always_ff @(posedge clk) begin
		if (commit) begin
			shash_mem[pb] <= run_hash_q;
			slen_mem[pb]  <= pcnt_q;
		end
		if (cmd == CMD_SCAN && !sa_q[BLK_W]) begin
			hrd_s1 <= shash_mem[sa_q[BLK_W-1:0]];
			lrd_s1 <= slen_mem[sa_q[BLK_W-1:0]];
			si_s1  <= sa_q[BLK_W-1:0];
		end
	end

	// reference counts
	always_ff @(posedge clk) begin
		if (rc_we) rcnt_mem[rc_wa] <= rc_wd;
		if (cmd == CMD_REF_RD) begin
			rc_rd_s1 <= rcnt_mem[ref_addr];
			iu_rd_s1 <= inuse_q[ref_addr];
		end
	end

	// free list, entries not yet written hold their own index
	always_ff @(posedge clk) begin
		if (push) fifo_mem[tail_q] <= rel_q;
		if (cmd == CMD_POP_RD) begin
			ffrd_q <= fifo_mem[head_q];
			hdrd_q <= head_q;
			ffw_q  <= (FREE_W'(head_q) < wcnt_q);
		end
	end

	// stored tokens
	always_ff @(posedge clk) begin
		if (cmd == CMD_FILL && fa_q < pcnt_q)
			stok_mem[{pb, fa_q[TIDX_W-1:0]}] <= pend_q[fa_q[TIDX_W-1:0]];
		if (cmd == CMD_CMP && ca_q < pcnt_q) begin
			trd_s1 <= stok_mem[{cand_q, ca_q[TIDX_W-1:0]}];
			ci_s1  <= ca_q[TIDX_W-1:0];
		end
	end

	assign tpb           = tpb_q;
	assign result_valid  = out_vld_q;
	assign block_num     = out_blk_q;
	assign cache_hit     = out_hit_q;
	assign status        = out_st_q;
	assign free_count    = out_free_q;
	assign hit_tokens    = out_reuse_q;
	assign sequence_done = out_done_q;

	// a registered block is always held by someone
	a_reg_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(reg_q & ~inuse_q) == '0)
		else $error("registered block not in use");

	// free list never overflows
	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= FREE_W'(POOL_BLOCKS))
		else $error("free count out of range");

	// a reused block is one that is registered
	a_hit_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_HIT_WR) |-> reg_q[cand_q])
		else $error("reuse of unregistered block");

	// a filled block becomes registered and owned
	a_fill_registers: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> (reg_q[pb] && inuse_q[pb]))
		else $error("filled block not registered");

endmodule

// ===== hdl/kv_block_allocator_prefix_cache.sv =====
// ----------------------------------------------------------------------------
// kv_block_allocator_prefix_cache
// Paged kv-cache block manager with reference counts, fifo free list and
// prefix caching by chained block hash.
// ----------------------------------------------------------------------------
// A token that ends no block only extends the hash chain and loads no result;
// a release reads and then writes the reference count, an append pops the free
// list, and a status query goes straight to the output register.
// A block-ending token also scans the hash table, which reads one block entry
// per cycle, then compares the tokens of the block or fills a new block; the
// token compare and fill touch one stored token per cycle.
// One transaction at a time; the result register frees the input side.
// Reset is immediate with no clearing pass; tokens_per_block resets to 16.
module kv_block_allocator_prefix_cache (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [2:0]                          paddr,
	input  logic [31:0]                         pwdata,
	output logic [31:0]                         prdata,
	output logic                                pready,
	// item channel
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [1:0]                          opcode,
	input  logic [kvbac_pkg::TOKEN_BITS-1:0]    token,
	input  logic                                last_token,
	input  logic [kvbac_pkg::BLK_W-1:0]         release_block,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic [kvbac_pkg::BLK_W-1:0]         block_num,
	output logic                                cache_hit,
	output logic [1:0]                          status,
	output logic [kvbac_pkg::FREE_W-1:0]        free_count,
	output logic [kvbac_pkg::REUSE_W-1:0]       hit_tokens,
	output logic                                sequence_done
);
	import kvbac_pkg::*;

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             idle, cfg_we;
	logic [CFG_W-1:0] tpb;

	// register access decode
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == 1'b0);
	assign prdata = (paddr[2] == 1'b0) ? {{(32-CFG_W){1'b0}}, tpb} : '0;
	assign item_stall = !idle;

	kvbac_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.opcode     (opcode),
		.stat       (stat),
		.cmd        (cmd),
		.idle       (idle)
	);

	kvbac_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_data      (pwdata[CFG_W-1:0]),
		.tpb           (tpb),
		.opcode        (opcode),
		.token         (token),
		.last_token    (last_token),
		.release_block (release_block),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.block_num     (block_num),
		.cache_hit     (cache_hit),
		.status        (status),
		.free_count    (free_count),
		.hit_tokens    (hit_tokens),
		.sequence_done (sequence_done)
	);

endmodule
